@@ rtl/sopl_pkg.sv @@
`default_nettype none

package sopl_pkg;

    // Register map of the configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 19;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TARGET_COEFFICIENT = 2'd0,
        CFG_MAKEUP_GAIN        = 2'd1,
        CFG_TARGET_BLEND       = 2'd2
    } cfg_index_t;

    localparam int COEF_W   = 16;
    localparam int MAKEUP_W = 19;
    localparam int BLEND_W  = 17;
    localparam int CHAN_W   = 3;

    localparam logic [COEF_W-1:0]   COEF_RESET   = 16'd50516;
    localparam logic [MAKEUP_W-1:0] MAKEUP_RESET = 19'd111022;
    localparam logic [BLEND_W-1:0]  BLEND_RESET  = 17'd65536;
    localparam logic [BLEND_W-1:0]  BLEND_ONE    = 17'd65536;

    // Smoothed state: coefficient Q0.32, blend Q1.31
    localparam int SMOOTH_W = 32;
    localparam logic [SMOOTH_W-1:0] CUR_COEF_RESET  = {COEF_RESET, 16'd0};
    localparam logic [SMOOTH_W-1:0] CUR_BLEND_RESET = 32'h8000_0000;

    typedef struct packed {
        logic [COEF_W-1:0]   target_coefficient;
        logic [MAKEUP_W-1:0] makeup_gain;
        logic [BLEND_W-1:0]  target_blend;
    } cfg_t;

    // Operand pair routed to the shared multiplier
    typedef enum logic [2:0] {
        MUL_MAKEUP = 3'd0,   // makeup * (1 - g)
        MUL_XM     = 3'd1,   // x * m
        MUL_PG     = 3'd2,   // prev * g
        MUL_XB     = 3'd3,   // x * (1 - b)
        MUL_BY     = 3'd4    // b * y
    } mul_sel_t;

    typedef struct packed {
        logic     load;       // capture the input word
        logic     smooth;     // step coefficient and blend toward targets
        logic     prod_en;    // register a new product
        mul_sel_t mul_sel;
        logic     acc_load;   // acc <= product
        logic     y_load;     // y <= rounded sum
        logic     out_load;   // output register <= saturated sum, write history
    } cmd_t;

    typedef struct packed {
        logic out_busy;       // output register holds a word not yet taken
    } status_t;

endpackage

`default_nettype wire

@@ rtl/sopl_cfg.sv @@
`default_nettype none

module sopl_cfg (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [sopl_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [sopl_pkg::CFG_DATA_W-1:0]    cfg_data,
    output sopl_pkg::cfg_t                          cfg
);

    sopl_pkg::cfg_t cfg_reg;
    sopl_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                sopl_pkg::CFG_TARGET_COEFFICIENT: begin
                    cfg_next.target_coefficient = cfg_data[sopl_pkg::COEF_W-1:0];
                end
                sopl_pkg::CFG_MAKEUP_GAIN: begin
                    cfg_next.makeup_gain = cfg_data[sopl_pkg::MAKEUP_W-1:0];
                end
                sopl_pkg::CFG_TARGET_BLEND: begin
                    cfg_next.target_blend = cfg_data[sopl_pkg::BLEND_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_coefficient <= sopl_pkg::COEF_RESET;
            cfg_reg.makeup_gain        <= sopl_pkg::MAKEUP_RESET;
            cfg_reg.target_blend       <= sopl_pkg::BLEND_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sopl_ctrl.sv @@
`default_nettype none

module sopl_ctrl (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    output sopl_pkg::cmd_t  cmd,
    input  wire sopl_pkg::status_t status
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SMOOTH = 8'b0000_0010,
        ST_MUL_M  = 8'b0000_0100,
        ST_MUL_XM = 8'b0000_1000,
        ST_MUL_PG = 8'b0001_0000,
        ST_SUM_Y  = 8'b0010_0000,
        ST_MUL_BY = 8'b0100_0000,
        ST_SUM_O  = 8'b1000_0000
    } sopl_state_t;

    sopl_state_t state_reg;
    sopl_state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.mul_sel  = sopl_pkg::MUL_MAKEUP;
        case (state_reg)
            ST_IDLE: begin
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_SMOOTH;
                end
            end
            ST_SMOOTH: begin
                cmd.smooth = 1'b1;
                state_next = ST_MUL_M;
            end
            ST_MUL_M: begin
                cmd.prod_en = 1'b1;
                cmd.mul_sel = sopl_pkg::MUL_MAKEUP;
                state_next  = ST_MUL_XM;
            end
            ST_MUL_XM: begin
                cmd.prod_en = 1'b1;
                cmd.mul_sel = sopl_pkg::MUL_XM;
                state_next  = ST_MUL_PG;
            end
            ST_MUL_PG: begin
                cmd.acc_load = 1'b1;
                cmd.prod_en  = 1'b1;
                cmd.mul_sel  = sopl_pkg::MUL_PG;
                state_next   = ST_SUM_Y;
            end
            ST_SUM_Y: begin
                cmd.y_load  = 1'b1;
                cmd.prod_en = 1'b1;
                cmd.mul_sel = sopl_pkg::MUL_XB;
                state_next  = ST_MUL_BY;
            end
            ST_MUL_BY: begin
                cmd.acc_load = 1'b1;
                cmd.prod_en  = 1'b1;
                cmd.mul_sel  = sopl_pkg::MUL_BY;
                state_next   = ST_SUM_O;
            end
            ST_SUM_O: begin
                // hold until the output register is free
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sopl_dp.sv @@
`default_nettype none

module sopl_dp #(
    parameter int CHANNELS     = 8,
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire sopl_pkg::cmd_t                 cmd,
    output sopl_pkg::status_t                   status,
    input  wire sopl_pkg::cfg_t                 cfg,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_sample_in,
    input  wire logic [sopl_pkg::CHAN_W-1:0]    s_channel,
    input  wire logic                           s_first_in_frame,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      m_sample_out
);

    localparam int SW         = SAMPLE_WIDTH;
    localparam int CH_SPAN    = 1 << sopl_pkg::CHAN_W;
    localparam int PREV_DEPTH = (CHANNELS < CH_SPAN) ? CHANNELS : CH_SPAN;
    localparam int PREV_IDX_W = (PREV_DEPTH > 1) ? $clog2(PREV_DEPTH) : 1;
    localparam int Y_W        = SW + 4;
    localparam int MA_W       = (Y_W > 20) ? Y_W : 20;
    localparam int MB_W       = 20;
    localparam int P_W        = MA_W + MB_W;
    localparam int ACC_W      = P_W + 1;
    localparam int SH_W       = ACC_W - 16;
    localparam int DIFF_W     = sopl_pkg::SMOOTH_W + 1;
    localparam int STEP_W     = DIFF_W + 7;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);
    localparam logic signed [SH_W-1:0]  OUT_MAX    = SH_W'((64'd1 << (SW - 1)) - 64'd1);
    localparam logic signed [SH_W-1:0]  OUT_MIN    = ~OUT_MAX;
    localparam logic [16:0]             ONE_Q16    = 17'd65536;

    function automatic logic [sopl_pkg::SMOOTH_W-1:0] smooth_step(
        input logic [sopl_pkg::SMOOTH_W-1:0] cur,
        input logic [sopl_pkg::SMOOTH_W-1:0] tgt
    );
        logic signed [DIFF_W-1:0] diff;
        logic signed [STEP_W-1:0] diff_ext;
        logic signed [STEP_W-1:0] diff66;
        logic [STEP_W-17:0]       step;
        diff     = $signed({1'b0, tgt}) - $signed({1'b0, cur});
        diff_ext = {{(STEP_W - DIFF_W){diff[DIFF_W-1]}}, diff};
        diff66   = (diff_ext <<< 6) + (diff_ext <<< 1);
        step     = diff66[STEP_W-1:16];
        return cur + {{(sopl_pkg::SMOOTH_W - (STEP_W - 16)){step[STEP_W-17]}}, step};
    endfunction

    // Captured input word
    logic signed [SW-1:0]               x_reg;
    logic [sopl_pkg::CHAN_W-1:0]        ch_reg;
    logic                               first_reg;

    logic [sopl_pkg::SMOOTH_W-1:0]      cur_coef_reg;
    logic [sopl_pkg::SMOOTH_W-1:0]      cur_blend_reg;
    logic signed [SW-1:0]               prev_reg [PREV_DEPTH];

    logic signed [P_W-1:0]              prod_reg;
    logic signed [ACC_W-1:0]            acc_reg;
    logic signed [Y_W-1:0]              y_reg;
    logic signed [SW-1:0]               out_reg;
    logic                               m_valid_reg;
    logic                               m_valid_next;

    logic                               in_range;
    logic [PREV_IDX_W-1:0]              prev_idx;
    logic signed [SW-1:0]               prev_val;
    logic [15:0]                        g;
    logic [16:0]                        b;
    logic [16:0]                        one_minus_g;
    logic [16:0]                        one_minus_b;
    logic [sopl_pkg::MAKEUP_W-1:0]      m;
    logic [sopl_pkg::BLEND_W-1:0]       blend_clamped;
    logic signed [MA_W-1:0]             mul_a;
    logic signed [MB_W-1:0]             mul_b;
    logic signed [P_W-1:0]              prod_w;
    logic signed [ACC_W-1:0]            sum_w;
    logic signed [SH_W-1:0]             sh_w;
    logic signed [SW-1:0]               sat_w;

    assign in_range = (32'(ch_reg) < CHANNELS);
    assign prev_idx = ch_reg[PREV_IDX_W-1:0];
    assign prev_val = in_range ? prev_reg[prev_idx] : '0;

    assign g           = cur_coef_reg[31:16];
    assign b           = cur_blend_reg[31:15];
    assign one_minus_g = ONE_Q16 - {1'b0, g};
    assign one_minus_b = ONE_Q16 - b;
    assign m           = prod_reg[34:16];

    assign blend_clamped = (cfg.target_blend > sopl_pkg::BLEND_ONE) ?
                           sopl_pkg::BLEND_ONE : cfg.target_blend;

    // Route one operand pair to the shared multiplier
    always_comb begin
        case (cmd.mul_sel)
            sopl_pkg::MUL_MAKEUP: begin
                mul_a = $signed({{(MA_W - sopl_pkg::MAKEUP_W){1'b0}}, cfg.makeup_gain});
                mul_b = $signed({{(MB_W - 17){1'b0}}, one_minus_g});
            end
            sopl_pkg::MUL_XM: begin
                mul_a = MA_W'(x_reg);
                mul_b = $signed({{(MB_W - sopl_pkg::MAKEUP_W){1'b0}}, m});
            end
            sopl_pkg::MUL_PG: begin
                mul_a = MA_W'(prev_val);
                mul_b = $signed({{(MB_W - 16){1'b0}}, g});
            end
            sopl_pkg::MUL_XB: begin
                mul_a = MA_W'(x_reg);
                mul_b = $signed({{(MB_W - 17){1'b0}}, one_minus_b});
            end
            sopl_pkg::MUL_BY: begin
                mul_a = MA_W'(y_reg);
                mul_b = $signed({{(MB_W - 17){1'b0}}, b});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_w = mul_a * mul_b;

    // Shared rounding adder: floor((acc + prod + half) / 2^16)
    assign sum_w = acc_reg + ACC_W'(prod_reg) + ROUND_HALF;
    assign sh_w  = sum_w[ACC_W-1:16];

    always_comb begin
        if (sh_w > OUT_MAX) begin
            sat_w = OUT_MAX[SW-1:0];
        end else if (sh_w < OUT_MIN) begin
            sat_w = OUT_MIN[SW-1:0];
        end else begin
            sat_w = sh_w[SW-1:0];
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign status.out_busy = m_valid_reg & ~m_ready;
    assign m_valid         = m_valid_reg;
    assign m_sample_out    = out_reg;

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg     <= s_sample_in;
            ch_reg    <= s_channel;
            first_reg <= s_first_in_frame;
        end
        if (cmd.prod_en) begin
            prod_reg <= prod_w;
        end
        if (cmd.acc_load) begin
            acc_reg <= ACC_W'(prod_reg);
        end
        if (cmd.y_load) begin
            y_reg <= sh_w[Y_W-1:0];
        end
        if (cmd.out_load) begin
            out_reg <= sat_w;
        end
    end

    // Filter state and output flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_coef_reg  <= sopl_pkg::CUR_COEF_RESET;
            cur_blend_reg <= sopl_pkg::CUR_BLEND_RESET;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < PREV_DEPTH; i++) begin
                prev_reg[i] <= '0;
            end
        end else begin
            m_valid_reg <= m_valid_next;
            if (cmd.smooth && first_reg) begin
                cur_coef_reg  <= smooth_step(cur_coef_reg,
                                             {cfg.target_coefficient, 16'd0});
                cur_blend_reg <= smooth_step(cur_blend_reg, {blend_clamped, 15'd0});
            end
            if (cmd.out_load && in_range) begin
                prev_reg[prev_idx] <= sat_w;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/smoothed_one_pole_lowpass_mix.sv @@
`default_nettype none

// Channel   Handshake              Word
// -------   --------------------   --------------------------------------------
// s_        s_valid / s_ready      s_sample_in, s_channel, s_first_in_frame
// m_        m_valid / m_ready      m_sample_out
// cfg_      cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// Each word is accepted, then the smoothed coefficient and blend are stepped
// (for a first-in-frame word only), then six steps run on the single shared
// multiplier and its rounding adder.
// Reset (aresetn low, synchronous) loads the default registers, the smoothed
// state and clears every channel's history; no clearing pass is needed.
// The output register frees the input side: a new word is accepted while the
// last result waits; the block stalls only at its final step when m_ready
// is held low and a result is still pending.

module smoothed_one_pole_lowpass_mix #(
    parameter int CHANNELS     = 8,
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [sopl_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [sopl_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]     s_sample_in,
    input  wire logic [sopl_pkg::CHAN_W-1:0]        s_channel,
    input  wire logic                               s_first_in_frame,

    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]          m_sample_out
);

    sopl_pkg::cfg_t    cfg;
    sopl_pkg::cmd_t    cmd;
    sopl_pkg::status_t status;

    // Register file for target coefficient, makeup gain and target blend
    sopl_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer: walk the multiply/accumulate schedule for one word
    sopl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // Smoothing, shared multiplier, rounding, saturation and channel history
    sopl_dp #(
        .CHANNELS     (CHANNELS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .cfg              (cfg),
        .s_sample_in      (s_sample_in),
        .s_channel        (s_channel),
        .s_first_in_frame (s_first_in_frame),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_sample_out     (m_sample_out)
    );

endmodule

`default_nettype wire
